// ----- sv/mlqs_pkg.sv -----
// ----------------------------------------------------------------------------
// mlqs_pkg: shared types and constants for the two-level queue scheduler
// Command and result records passed between the front, the back end and the
// top level.
// ----------------------------------------------------------------------------
package mlqs_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;

    localparam int unsigned ID_W    = 8;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned TIME_W  = 32;

    // Classified command kinds
    typedef enum logic [1:0] {
        K_ARR_USR = 2'd0,
        K_ARR_SYS = 2'd1,
        K_TICK    = 2'd2
    } t_cmd_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_QUEUED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_RAN     = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
    } t_cmd;

    // Queue entry: id and time left
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] left;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    ran_id;
        logic               finished;
        logic [TIME_W-1:0]  time_now;
    } t_result;

endpackage

// ----- sv/mlqs_front.sv -----
// ----------------------------------------------------------------------------
// mlqs_front: input acceptance and classification
// Decode each item into a command and hold it in a two-entry queue that
// decouples the input from the back end.
// ----------------------------------------------------------------------------
module mlqs_front import mlqs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [23:0]        i_s_tdata,   // job_id[7:0], burst[23:8]
    input  logic [1:0]         i_s_tuser,   // operation[0], is_system[1]
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.id    = i_s_tdata[ID_W-1:0];
        w_cmd.burst = i_s_tdata[ID_W +: BURST_W];
        if (i_s_tuser[0]) begin
            w_cmd.kind = K_TICK;
        end else if (i_s_tuser[1]) begin
            w_cmd.kind = K_ARR_SYS;
        end else begin
            w_cmd.kind = K_ARR_USR;
        end
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/mlqs_back.sv -----
// ----------------------------------------------------------------------------
// mlqs_back: scheduling engine
// Hold both job queues in memories, run arrivals, preemption, selection and
// one unit of service per tick, and hand one result per command onwards.
// ----------------------------------------------------------------------------
module mlqs_back import mlqs_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_ready,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_sys_head, n_sys_head;
    logic [CNT_W-1:0]   r_sys_cnt, n_sys_cnt;
    logic [PTR_W-1:0]   r_usr_head, n_usr_head;
    logic [CNT_W-1:0]   r_usr_cnt, n_usr_cnt;
    logic               r_run_valid, n_run_valid;
    logic [ID_W-1:0]    r_run_id, n_run_id;
    logic               r_run_sys, n_run_sys;
    logic [BURST_W-1:0] r_run_left, n_run_left;
    logic [TIME_W-1:0]  r_time, n_time;
    logic               r_pop_sys, n_pop_sys;

    t_entry             r_sys_mem [QUEUE_DEPTH];
    t_entry             r_usr_mem [QUEUE_DEPTH];
    t_entry             r_sys_rd;
    t_entry             r_usr_rd;

    logic               w_sys_we, w_usr_we, w_sys_re, w_usr_re;
    t_entry             w_sys_wdata, w_usr_wdata;
    logic [PTR_W-1:0]   w_sys_tail, w_usr_tail;
    logic               w_preempt;
    t_entry             w_pop_entry;
    logic [ID_W-1:0]    w_src_id;
    logic [BURST_W-1:0] w_src_left;
    logic [BURST_W-1:0] w_dec_left;
    logic               w_fin;

    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(cnt);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == LAST_C) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign w_sys_tail  = f_slot(r_sys_head, r_sys_cnt);
    assign w_usr_tail  = f_slot(r_usr_head, r_usr_cnt);
    assign w_preempt   = r_run_valid && !r_run_sys && (r_sys_cnt != '0)
                         && (r_usr_cnt != DEPTH_C);
    assign w_pop_entry = r_pop_sys ? r_sys_rd : r_usr_rd;

    // Service one unit: from the running job, or from the freshly popped one
    always_comb begin
        if (r_state == S_READ) begin
            w_src_id   = w_pop_entry.id;
            w_src_left = w_pop_entry.left;
        end else begin
            w_src_id   = r_run_id;
            w_src_left = r_run_left;
        end
        w_dec_left = (w_src_left == '0) ? '0 : w_src_left - BURST_W'(1);
        w_fin      = (w_dec_left == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_sys_head  = r_sys_head;
        n_sys_cnt   = r_sys_cnt;
        n_usr_head  = r_usr_head;
        n_usr_cnt   = r_usr_cnt;
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_run_sys   = r_run_sys;
        n_run_left  = r_run_left;
        n_time      = r_time;
        n_pop_sys   = r_pop_sys;
        w_sys_we    = 1'b0;
        w_usr_we    = 1'b0;
        w_sys_re    = 1'b0;
        w_usr_re    = 1'b0;
        w_sys_wdata = '{id: i_cmd.id, left: i_cmd.burst};
        w_usr_wdata = '{id: i_cmd.id, left: i_cmd.burst};
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_IDLE, ran_id: '0, finished: 1'b0, time_now: r_time};

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_ARR_SYS: begin
                            if (i_res_ready) begin
                                o_cmd_pop   = 1'b1;
                                o_res_valid = 1'b1;
                                if (r_sys_cnt == DEPTH_C) begin
                                    o_res.status = ST_DROPPED;
                                end else begin
                                    o_res.status = ST_QUEUED;
                                    w_sys_we     = 1'b1;
                                    n_sys_cnt    = r_sys_cnt + CNT_W'(1);
                                end
                            end
                        end
                        K_ARR_USR: begin
                            if (i_res_ready) begin
                                o_cmd_pop   = 1'b1;
                                o_res_valid = 1'b1;
                                if (r_usr_cnt == DEPTH_C) begin
                                    o_res.status = ST_DROPPED;
                                end else begin
                                    o_res.status = ST_QUEUED;
                                    w_usr_we     = 1'b1;
                                    n_usr_cnt    = r_usr_cnt + CNT_W'(1);
                                end
                            end
                        end
                        K_TICK: begin
                            if ((!r_run_valid || w_preempt) &&
                                ((r_sys_cnt != '0) || (r_usr_cnt != '0))) begin
                                // Send a preempted user job to the back of its queue,
                                // then start the read of the job to run next.
                                if (w_preempt) begin
                                    w_usr_we    = 1'b1;
                                    w_usr_wdata = '{id: r_run_id, left: r_run_left};
                                    n_usr_cnt   = r_usr_cnt + CNT_W'(1);
                                end
                                n_run_valid = 1'b0;
                                if (r_sys_cnt != '0) begin
                                    w_sys_re   = 1'b1;
                                    n_sys_head = f_inc(r_sys_head);
                                    n_sys_cnt  = r_sys_cnt - CNT_W'(1);
                                    n_pop_sys  = 1'b1;
                                end else begin
                                    w_usr_re   = 1'b1;
                                    n_usr_head = f_inc(r_usr_head);
                                    n_usr_cnt  = r_usr_cnt - CNT_W'(1);
                                    n_pop_sys  = 1'b0;
                                end
                                n_state = S_READ;
                            end else if (i_res_ready) begin
                                o_cmd_pop      = 1'b1;
                                o_res_valid    = 1'b1;
                                n_time         = r_time + TIME_W'(1);
                                o_res.time_now = r_time + TIME_W'(1);
                                if (r_run_valid) begin
                                    o_res.status   = ST_RAN;
                                    o_res.ran_id   = w_src_id;
                                    o_res.finished = w_fin;
                                    n_run_left     = w_dec_left;
                                    n_run_valid    = !w_fin;
                                end else begin
                                    o_res.status = ST_IDLE;
                                end
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_res_ready) begin
                    o_cmd_pop      = 1'b1;
                    o_res_valid    = 1'b1;
                    n_time         = r_time + TIME_W'(1);
                    o_res.time_now = r_time + TIME_W'(1);
                    o_res.status   = ST_RAN;
                    o_res.ran_id   = w_src_id;
                    o_res.finished = w_fin;
                    n_run_id       = w_src_id;
                    n_run_sys      = r_pop_sys;
                    n_run_left     = w_dec_left;
                    n_run_valid    = !w_fin;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_sys_we) begin
            r_sys_mem[w_sys_tail] <= w_sys_wdata;
        end
        if (w_sys_re) begin
            r_sys_rd <= r_sys_mem[r_sys_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_usr_we) begin
            r_usr_mem[w_usr_tail] <= w_usr_wdata;
        end
        if (w_usr_re) begin
            r_usr_rd <= r_usr_mem[r_usr_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sys_head  <= '0;
            r_sys_cnt   <= '0;
            r_usr_head  <= '0;
            r_usr_cnt   <= '0;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_sys   <= 1'b0;
            r_run_left  <= '0;
            r_time      <= '0;
            r_pop_sys   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sys_head  <= n_sys_head;
            r_sys_cnt   <= n_sys_cnt;
            r_usr_head  <= n_usr_head;
            r_usr_cnt   <= n_usr_cnt;
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_run_sys   <= n_run_sys;
            r_run_left  <= n_run_left;
            r_time      <= n_time;
            r_pop_sys   <= n_pop_sys;
        end
    end

endmodule

// ----- sv/two_level_preemptive_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// two_level_preemptive_queue_scheduler: two-level preemptive job scheduler
// System and user job queues, advanced one time unit per tick item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Contents
//  s_*       in         i_s_tvalid/o_s_tready  arrival (id, burst, queue) or tick
//  m_*       out        o_m_tvalid/i_m_tready  status, job run, finish flag, time
//
//  Engine steps: an arrival, or a tick that keeps the running job or finds
//  nothing to do, is handled in S_IDLE alone; a tick that starts a new job
//  goes through S_IDLE and then S_READ, for the registered memory read port.
//  Reset: i_rst_n synchronous, active low; both queues empty, clock at zero.
//  Stalls: a two-entry command queue keeps input taken while the engine
//  works; the output register takes a result when it is empty or draining,
//  and while a result waits there the engine holds its command.
// ----------------------------------------------------------------------------
module two_level_preemptive_queue_scheduler import mlqs_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // job_id[7:0], burst[23:8]
    input  logic [1:0]  i_s_tuser,  // operation[0], is_system[1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,  // ran_id[7:0], finished[8], time_now[40:9], zeros
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;

    logic    r_out_valid;
    t_result r_out;

    // Front: accept and classify items into the command queue
    mlqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Back: queues, preemption, selection and service
    mlqs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register: load when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out.time_now, r_out.finished, r_out.ran_id};
    assign o_m_tuser  = r_out.status;

endmodule

// ----- sim/two_level_preemptive_queue_scheduler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_preemptive_queue_scheduler_tb: self-checking bench for the scheduler
// Drives arrival and tick items on the input stream and predicts every result
// with a software copy of the two queues, the running job and the time count.
// Results are matched in order, field by field. Both stream sides idle at
// random, and the result side holds off once for long enough to fill the
// command path and stall the input.
// ----------------------------------------------------------------------------
module two_level_preemptive_queue_scheduler_tb import mlqs_pkg::*; ;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam int unsigned DEPTH           = QUEUE_DEPTH_DEF;
    localparam int unsigned ITEM_TARGET     = 520;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned HOLD_OFF_AFTER  = 40;    // results seen before the hold-off
    localparam int unsigned WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
    localparam int unsigned DRAIN_CYCLES    = 20;

    // ------------------------------------------------------------------------
    // Scheduler shadow: mirrors the queues, the running job and the time count,
    // and keeps the results still owed by the block in arrival order.
    // ------------------------------------------------------------------------
    class sched_scoreboard;
        t_entry        system_jobs[$];
        t_entry        user_jobs[$];
        bit            job_active;
        bit            job_is_system;
        t_entry        job;
        logic [31:0]   now;
        t_result       owed_results[$];
        int unsigned   errors;

        function new();
            job_active    = 1'b0;
            job_is_system = 1'b0;
            job           = '0;
            now           = '0;
            errors        = 0;
        endfunction

        // Work out the result of one accepted item and queue it.
        function void note_item(logic op, logic [7:0] id, logic [15:0] burst, logic sys);
            t_result r;
            t_entry  e;
            r       = '0;
            e.id    = id;
            e.left  = burst;
            if (op == OP_ARRIVAL) begin
                if (sys) begin
                    if (system_jobs.size() >= DEPTH) begin
                        r.status = ST_DROPPED;
                    end else begin
                        system_jobs.push_back(e);
                        r.status = ST_QUEUED;
                    end
                end else begin
                    if (user_jobs.size() >= DEPTH) begin
                        r.status = ST_DROPPED;
                    end else begin
                        user_jobs.push_back(e);
                        r.status = ST_QUEUED;
                    end
                end
            end else begin
                // Send a user job back when system work waits, unless its queue is full
                if (job_active && !job_is_system && system_jobs.size() > 0 &&
                    user_jobs.size() < DEPTH) begin
                    user_jobs.push_back(job);
                    job_active = 1'b0;
                end
                if (!job_active) begin
                    if (system_jobs.size() > 0) begin
                        job           = system_jobs.pop_front();
                        job_is_system = 1'b1;
                        job_active    = 1'b1;
                    end else if (user_jobs.size() > 0) begin
                        job           = user_jobs.pop_front();
                        job_is_system = 1'b0;
                        job_active    = 1'b1;
                    end
                end
                now = now + 32'd1;
                if (!job_active) begin
                    r.status = ST_IDLE;
                end else begin
                    // A zero burst runs once and finishes without wrapping
                    if (job.left != '0) begin
                        job.left = job.left - 16'd1;
                    end
                    r.status = ST_RAN;
                    r.ran_id = job.id;
                    if (job.left == '0) begin
                        r.finished = 1'b1;
                        job_active = 1'b0;
                    end
                end
            end
            r.time_now = now;
            owed_results.push_back(r);
        endfunction

        function void report_field(string name, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        endfunction

        // Compare one accepted result with the oldest owed one.
        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d id %0d",
                         $time, got.status, got.ran_id);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
                report_field("status", want.status, got.status);
            if (got.ran_id !== want.ran_id)
                report_field("ran_id", want.ran_id, got.ran_id);
            if (got.finished !== want.finished)
                report_field("finished", want.finished, got.finished);
            if (got.time_now !== want.time_now)
                report_field("time_now", want.time_now, got.time_now);
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // job_id[7:0], burst[23:8]
    logic [1:0]  i_s_tuser;   // operation[0], is_system[1]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // ran_id[7:0], finished[8], time_now[40:9], zeros
    logic [1:0]  o_m_tuser;   // status[1:0]

    sched_scoreboard sb;
    int unsigned     items_sent;
    int unsigned     results_seen;
    int unsigned     quiet_cycles;
    int unsigned     sender_free_run;

    two_level_preemptive_queue_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle cycles before the next item: mostly none or short, now and then long,
    // with stretches of back-to-back items.
    function automatic int unsigned sender_gap();
        int unsigned roll;
        if (sender_free_run > 0) begin
            sender_free_run--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            sender_free_run = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one item, hold it until taken, then note it in the shadow.
    task automatic send_item(logic op, logic [7:0] id, logic [15:0] burst, logic sys);
        int unsigned gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {burst, id};
        i_s_tuser  <= {sys, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(op, id, burst, sys);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Random arrival or tick; long bursts go only to the user queue so that
    // no system job can hold the processor for the rest of the run.
    task automatic send_random_item();
        logic        sys;
        logic [15:0] burst;
        int unsigned roll;
        if ($urandom_range(0, 99) < 55) begin
            send_tick();
        end else begin
            sys  = ($urandom_range(0, 99) < 35);
            roll = $urandom_range(0, 99);
            if (roll < 4)
                burst = '0;
            else if (roll < 9 && !sys)
                burst = 16'($urandom);
            else
                burst = 16'($urandom_range(1, 6));
            send_item(OP_ARRIVAL, 8'($urandom), burst, sys);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        sb              = new();
        items_sent      = 0;
        sender_free_run = 0;
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick, zero burst, preemption of a user job, a running
        // system job left alone while more system work waits, id extremes.
        send_tick();
        send_item(OP_ARRIVAL, 8'd0,   16'd0, 1'b0);
        send_item(OP_ARRIVAL, 8'd255, 16'd4, 1'b0);
        send_tick();
        send_tick();
        send_item(OP_ARRIVAL, 8'hA5,  16'd2, 1'b1);
        send_tick();
        send_item(OP_ARRIVAL, 8'h5A,  16'd1, 1'b1);
        repeat (6) send_tick();

        // Fill both queues behind a running user job: overflow arrivals are
        // dropped, and the tick after finds the preemption held off.
        send_item(OP_ARRIVAL, 8'($urandom), 16'd3, 1'b0);
        send_tick();
        repeat (DEPTH) send_item(OP_ARRIVAL, 8'($urandom), 16'($urandom_range(1, 2)), 1'b0);
        send_item(OP_ARRIVAL, 8'd255, 16'hFFFF, 1'b0);
        send_item(OP_ARRIVAL, 8'($urandom), 16'($urandom), 1'b0);
        repeat (DEPTH) send_item(OP_ARRIVAL, 8'($urandom), 16'($urandom_range(1, 2)), 1'b1);
        send_item(OP_ARRIVAL, 8'($urandom), 16'($urandom), 1'b1);
        send_item(OP_ARRIVAL, 8'd0, 16'hFFFF, 1'b1);
        send_tick();

        // Random mix for the rest
        while (items_sent < ITEM_TARGET) send_random_item();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, quiet stretches, and one long hold-off once
    // enough results have come to have the command path filling up behind it.
    // ------------------------------------------------------------------------
    initial begin
        bit          held_off;
        int unsigned stall;
        int unsigned free_run;
        int unsigned roll;
        held_off   = 1'b0;
        stall      = 0;
        free_run   = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_m_tready <= 1'b0;
            end else if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
                held_off   = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
                if (free_run > 0) begin
                    free_run--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 25)
                        stall = $urandom_range(1, 3);
                    else if (roll < 28)
                        stall = $urandom_range(8, 40);
                    else if (roll < 32)
                        free_run = $urandom_range(30, 100);
                end
            end
        end
    end

    // Take each result at the edge it is accepted and check it
    initial results_seen = 0;
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status   = t_status'(o_m_tuser);
            got.ran_id   = o_m_tdata[7:0];
            got.finished = o_m_tdata[8];
            got.time_now = o_m_tdata[40:9];
            sb.check_result(got);
            results_seen++;
        end
    end

    // Give up when neither side moves for too long
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

endmodule

// ----- two_level_preemptive_queue_scheduler.f -----
sv/mlqs_pkg.sv
sv/mlqs_front.sv
sv/mlqs_back.sv
sv/two_level_preemptive_queue_scheduler.sv
sim/two_level_preemptive_queue_scheduler_tb.sv
